/* hdl/vpo_pkg.sv */
`default_nettype none

package vpo_pkg;

  // grid edge in voxels; indices at or above it never hit
  localparam int unsigned GridDim = 1024;

  localparam int unsigned IdxW   = 10;
  localparam int unsigned VsW    = 12;
  localparam int unsigned PosW   = IdxW + VsW;   // scaled voxel position
  localparam int unsigned LenW   = 20;           // translation and extent lanes
  localparam int unsigned DiffW  = PosW + 2;     // point minus translation, signed
  localparam int unsigned RotW   = 16;           // Q1.14 rotation entry
  localparam int unsigned FracW  = 14;
  localparam int unsigned ProdW  = RotW + DiffW;
  localparam int unsigned AccW   = ProdW + 2;
  localparam int unsigned QW     = AccW - FracW; // object-frame coordinate
  localparam int unsigned SqW    = 2 * QW;
  localparam int unsigned CfgW   = 3 * LenW;
  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned LimW   = 13;

  localparam logic [LimW-1:0] GridLimit = LimW'(GridDim);

  // configuration register indexes
  localparam logic [CfgIdxW-1:0] CfgShapeKind   = 3'd0;
  localparam logic [CfgIdxW-1:0] CfgRotRow0     = 3'd1;
  localparam logic [CfgIdxW-1:0] CfgRotRow1     = 3'd2;
  localparam logic [CfgIdxW-1:0] CfgRotRow2     = 3'd3;
  localparam logic [CfgIdxW-1:0] CfgTranslation = 3'd4;
  localparam logic [CfgIdxW-1:0] CfgExtents     = 3'd5;
  localparam logic [CfgIdxW-1:0] CfgVoxelSize   = 3'd6;

  localparam logic ShapeBox      = 1'b0;
  localparam logic ShapeCylinder = 1'b1;

  localparam logic [3*RotW-1:0] RotRow0Reset = 48'h0000_0000_4000;
  localparam logic [3*RotW-1:0] RotRow1Reset = 48'h0000_4000_0000;
  localparam logic [3*RotW-1:0] RotRow2Reset = 48'h4000_0000_0000;
  localparam logic [VsW-1:0]    VoxelSizeReset = 12'd500;

  typedef logic signed [DiffW-1:0] diff_t;
  typedef logic signed [ProdW-1:0] prod_t;
  typedef logic signed [QW-1:0]    coord_t;

  // -p <= 2q <= p, exact
  function automatic logic in_span(input coord_t q, input logic [LenW-1:0] p);
    logic signed [QW+1:0] twice;
    logic signed [QW+1:0] lim;
    twice = {q[QW-1], q, 1'b0};
    lim   = $signed({{(QW+2-LenW){1'b0}}, p});
    return (twice <= lim) && (twice >= -lim);
  endfunction

endpackage

`default_nettype wire

/* hdl/voxel_primitive_occupancy.sv */
`default_nettype none

// channel  | direction | handshake                  | payload
// ---------+-----------+----------------------------+------------------------------------
// in       | input     | in_valid_i / in_stall_o    | vox_x_i, vox_y_i, vox_z_i,
//          |           |                            | prior_occupied_i
// out      | output    | out_valid_o / out_stall_i  | occupied_o
// cfg      | input     | cfg_we_i (no wait)         | cfg_idx_i, cfg_data_i
//
// one beat per cycle sustained while the output is not stalled; a beat passes
// through the stage registers in order to the output register (scale/subtract,
// 9 products, sums, squares and extent compares, radius compare)
// each stage moves on when it is empty or the stage after it moves, so
// bubbles close up and the input only stalls when all five stages are full
// and the output is stalled
// reset clears the stage valid bits and loads the identity pose

module voxel_primitive_occupancy
  import vpo_pkg::*;
(
  input  wire                 clk_i,
  input  wire                 rst_ni,

  input  wire                 in_valid_i,
  output logic                in_stall_o,
  input  wire  [IdxW-1:0]     vox_x_i,
  input  wire  [IdxW-1:0]     vox_y_i,
  input  wire  [IdxW-1:0]     vox_z_i,
  input  wire                 prior_occupied_i,

  output logic                out_valid_o,
  input  wire                 out_stall_i,
  output logic                occupied_o,

  input  wire                 cfg_we_i,
  input  wire  [CfgIdxW-1:0]  cfg_idx_i,
  input  wire  [CfgW-1:0]     cfg_data_i
);

  // ---------------------------------------------------------------
  // configuration registers
  // ---------------------------------------------------------------
  logic                 shape_kind_q;
  logic [3*RotW-1:0]    rot_row_q [3];
  logic [CfgW-1:0]      translation_q;
  logic [CfgW-1:0]      extents_q;
  logic [VsW-1:0]       voxel_size_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      shape_kind_q  <= ShapeBox;
      rot_row_q[0]  <= RotRow0Reset;
      rot_row_q[1]  <= RotRow1Reset;
      rot_row_q[2]  <= RotRow2Reset;
      translation_q <= '0;
      extents_q     <= '0;
      voxel_size_q  <= VoxelSizeReset;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CfgShapeKind:   shape_kind_q  <= cfg_data_i[0];
        CfgRotRow0:     rot_row_q[0]  <= cfg_data_i[3*RotW-1:0];
        CfgRotRow1:     rot_row_q[1]  <= cfg_data_i[3*RotW-1:0];
        CfgRotRow2:     rot_row_q[2]  <= cfg_data_i[3*RotW-1:0];
        CfgTranslation: translation_q <= cfg_data_i;
        CfgExtents:     extents_q     <= cfg_data_i;
        CfgVoxelSize:   voxel_size_q  <= cfg_data_i[VsW-1:0];
        default: ;  // unused index, write dropped
      endcase
    end
  end

  // extent lanes: box a, b, c; cylinder height in lane 0, radius in lane 1
  logic [LenW-1:0] ext_p1, ext_p2, ext_p3;
  assign ext_p1 = extents_q[LenW-1:0];
  assign ext_p2 = extents_q[2*LenW-1:LenW];
  assign ext_p3 = extents_q[3*LenW-1:2*LenW];

  // ---------------------------------------------------------------
  // stage flow control
  // ---------------------------------------------------------------
  logic v1_q, v2_q, v3_q, v4_q, v5_q;
  logic rdy1, rdy2, rdy3, rdy4, rdy5;

  assign rdy5 = !v5_q || !out_stall_i;
  assign rdy4 = !v4_q || rdy5;
  assign rdy3 = !v3_q || rdy4;
  assign rdy2 = !v2_q || rdy3;
  assign rdy1 = !v1_q || rdy2;

  assign in_stall_o  = !rdy1;
  assign out_valid_o = v5_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
      v5_q <= 1'b0;
    end else begin
      if (rdy1) v1_q <= in_valid_i;
      if (rdy2) v2_q <= v1_q;
      if (rdy3) v3_q <= v2_q;
      if (rdy4) v4_q <= v3_q;
      if (rdy5) v5_q <= v4_q;
    end
  end

  // ---------------------------------------------------------------
  // stage 1: scale index by voxel size, subtract translation
  // ---------------------------------------------------------------
  logic [IdxW-1:0] idx [3];
  diff_t           d_d [3];
  diff_t           d_q [3];
  logic            hit1_d, hit1_q;   // index inside the grid, and'd later
  logic            prior1_q;

  assign idx[0] = vox_x_i;
  assign idx[1] = vox_y_i;
  assign idx[2] = vox_z_i;

  always_comb begin
    logic [PosW-1:0] pos;
    logic [LenW-1:0] t;
    for (int j = 0; j < 3; j++) begin
      pos    = {{IdxW{1'b0}}, voxel_size_q} * {{VsW{1'b0}}, idx[j]};
      t      = translation_q[LenW*j +: LenW];
      d_d[j] = $signed({2'b00, pos}) - $signed({{(DiffW-LenW){t[LenW-1]}}, t});
    end
    hit1_d = ({{(LimW-IdxW){1'b0}}, vox_x_i} < GridLimit) &&
             ({{(LimW-IdxW){1'b0}}, vox_y_i} < GridLimit) &&
             ({{(LimW-IdxW){1'b0}}, vox_z_i} < GridLimit);
  end

  always_ff @(posedge clk_i) begin
    if (rdy1) begin
      d_q      <= d_d;
      hit1_q   <= hit1_d;
      prior1_q <= prior_occupied_i;
    end
  end

  // ---------------------------------------------------------------
  // stage 2: nine products R[j][i] * d[j]
  // ---------------------------------------------------------------
  prod_t prod_d [3][3];   // [i][j]
  prod_t prod_q [3][3];
  logic  hit2_q, prior2_q;

  always_comb begin
    logic [RotW-1:0] r;
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        r = rot_row_q[j][RotW*i +: RotW];
        prod_d[i][j] = $signed({{(ProdW-RotW){r[RotW-1]}}, r}) *
                       $signed({{(ProdW-DiffW){d_q[j][DiffW-1]}}, d_q[j]});
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy2) begin
      prod_q   <= prod_d;
      hit2_q   <= hit1_q;
      prior2_q <= prior1_q;
    end
  end

  // ---------------------------------------------------------------
  // stage 3: sum and drop the Q1.14 fraction (floor)
  // ---------------------------------------------------------------
  coord_t q_d [3];
  coord_t q_q [3];
  logic   hit3_q, prior3_q;

  always_comb begin
    logic signed [AccW-1:0] acc;
    for (int i = 0; i < 3; i++) begin
      acc = $signed({{2{prod_q[i][0][ProdW-1]}}, prod_q[i][0]}) +
            $signed({{2{prod_q[i][1][ProdW-1]}}, prod_q[i][1]}) +
            $signed({{2{prod_q[i][2][ProdW-1]}}, prod_q[i][2]});
      q_d[i] = acc[AccW-1:FracW];
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy3) begin
      q_q      <= q_d;
      hit3_q   <= hit2_q;
      prior3_q <= prior2_q;
    end
  end

  // ---------------------------------------------------------------
  // stage 4: squares for the radius test, per-axis extent compares
  // ---------------------------------------------------------------
  logic [SqW-1:0]    sq0_d, sq1_d, sq0_q, sq1_q;
  logic [2*LenW-1:0] r2_d, r2_q;
  logic              axial_d, axial_q;   // box: all three axes; cylinder: z only
  logic              cyl4_q, hit4_q, prior4_q;

  always_comb begin
    logic signed [SqW-1:0] sx, sy;
    sx    = $signed({{QW{q_q[0][QW-1]}}, q_q[0]}) * $signed({{QW{q_q[0][QW-1]}}, q_q[0]});
    sy    = $signed({{QW{q_q[1][QW-1]}}, q_q[1]}) * $signed({{QW{q_q[1][QW-1]}}, q_q[1]});
    sq0_d = sx;
    sq1_d = sy;
    r2_d  = {{LenW{1'b0}}, ext_p2} * {{LenW{1'b0}}, ext_p2};
    unique case (shape_kind_q)
      ShapeBox:      axial_d = in_span(q_q[0], ext_p1) && in_span(q_q[1], ext_p2) &&
                               in_span(q_q[2], ext_p3);
      ShapeCylinder: axial_d = in_span(q_q[2], ext_p1);
      default:       axial_d = 1'b0;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (rdy4) begin
      sq0_q    <= sq0_d;
      sq1_q    <= sq1_d;
      r2_q     <= r2_d;
      axial_q  <= axial_d;
      cyl4_q   <= (shape_kind_q == ShapeCylinder);
      hit4_q   <= hit3_q;
      prior4_q <= prior3_q;
    end
  end

  // ---------------------------------------------------------------
  // stage 5: radius compare, merge with prior occupancy
  // ---------------------------------------------------------------
  logic occupied_d, occupied_q;

  always_comb begin
    logic [SqW:0] rad2;
    logic         radial_ok;
    rad2       = {1'b0, sq0_q} + {1'b0, sq1_q};
    radial_ok  = !cyl4_q || (rad2 <= {{(SqW+1-2*LenW){1'b0}}, r2_q});
    occupied_d = prior4_q || (hit4_q && axial_q && radial_ok);
  end

  always_ff @(posedge clk_i) begin
    if (rdy5) occupied_q <= occupied_d;
  end

  assign occupied_o = occupied_q;

endmodule

`default_nettype wire
